// ===== hdl/assert_macros.svh =====
// Assertion macros for the frustum culling RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FCT_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define FCT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define FCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FCT_ASSERT(lbl, cond, msg)
`define FCT_ASSERT_IMP(lbl, ante, cons, msg)
`define FCT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/fct_pkg.sv =====
// Types, constants and helper functions of the frustum culling tester.
package fct_pkg;

  localparam int NUM_PLANES = 6;
  localparam int CIDX_W = ($clog2(NUM_PLANES) > 3) ? $clog2(NUM_PLANES) : 3;
  // Three products of Q1.15 by adjusted Q16.16 values plus the offset term, in Q.31.
  localparam int ACC_W = 52;
  localparam int FRAC_SHIFT = 15;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_POINT  = 2'd1,
    CMD_SPHERE = 2'd2,
    CMD_BOX    = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [2:0]         plane_index;
    logic signed [15:0] plane_a;
    logic signed [15:0] plane_b;
    logic signed [15:0] plane_c;
    logic signed [31:0] plane_offset;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        extent_x;
    logic [30:0]        extent_y;
    logic [30:0]        extent_z;
    logic               vis;
  } item_t;

  // For a box, the farthest corner along the normal moves the coordinate by the
  // half size toward the sign of the normal component.
  function automatic logic signed [32:0] corner_coord(logic signed [31:0] p,
                                                      logic [30:0] e,
                                                      logic neg,
                                                      logic box);
    logic signed [32:0] pe;
    logic signed [32:0] ee;
    logic signed [32:0] res;
    pe = 33'(p);
    ee = $signed({2'b00, e});
    if (!box) begin
      res = pe;
    end else if (neg) begin
      res = pe - ee;
    end else begin
      res = pe + ee;
    end
    return res;
  endfunction

endpackage

// ===== hdl/fct_cell.sv =====
// One plane of the culling chain: plane storage and a three-stage dot product.
module fct_cell
  import fct_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [CIDX_W-1:0] cell_idx,
  input  logic              in_valid,
  output logic              in_ready,
  input  item_t             in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output item_t             out_item
);

  logic signed [15:0] pa, pb, pc;
  logic signed [31:0] pd;

  logic               v1, v2, v3;
  logic               rdy1, rdy2, rdy3;
  item_t              it1, it2, it3;
  item_t              it3_next;
  logic signed [ACC_W-1:0] acc1, acc2;
  logic signed [15:0] b1, c1, c2;

  logic signed [32:0] xa, ya, za;
  logic signed [32:0] koff;
  logic signed [48:0] prod0, prod1, prod2;
  logic signed [ACC_W-1:0] acc1_next, acc2_next, sum;
  logic               load_hit;

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // A load is taken when it reaches this cell, so earlier tests keep the old plane.
  assign load_hit = in_valid && rdy1 && (in_item.cmd == CMD_LOAD) &&
                    (CIDX_W'(in_item.plane_index) == cell_idx);

  always_comb begin
    xa = corner_coord(in_item.center_x, in_item.extent_x, pa[15], in_item.cmd == CMD_BOX);
    if (in_item.cmd == CMD_SPHERE) begin
      koff = 33'(pd) + $signed({2'b00, in_item.extent_x});
    end else begin
      koff = 33'(pd);
    end
    prod0     = pa * xa;
    acc1_next = (ACC_W'(koff) <<< FRAC_SHIFT) + ACC_W'(prod0);
  end

  always_comb begin
    ya        = corner_coord(it1.center_y, it1.extent_y, b1[15], it1.cmd == CMD_BOX);
    prod1     = b1 * ya;
    acc2_next = acc1 + ACC_W'(prod1);
  end

  always_comb begin
    za           = corner_coord(it2.center_z, it2.extent_z, c2[15], it2.cmd == CMD_BOX);
    prod2        = c2 * za;
    sum          = acc2 + ACC_W'(prod2);
    it3_next     = it2;
    it3_next.vis = it2.vis && !sum[ACC_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pa <= '0;
      pb <= '0;
      pc <= '0;
      pd <= '0;
    end else if (load_hit) begin
      pa <= in_item.plane_a;
      pb <= in_item.plane_b;
      pc <= in_item.plane_c;
      pd <= in_item.plane_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      it1  <= in_item;
      acc1 <= acc1_next;
      b1   <= pb;
      c1   <= pc;
    end
    if (rdy2) begin
      it2  <= it1;
      acc2 <= acc2_next;
      c2   <= c1;
    end
    if (rdy3) begin
      it3 <= it3_next;
    end
  end

  assign out_valid = v3;
  assign out_item  = it3;

endmodule

// ===== hdl/frustum_cull_tester_core.sv =====
// Top level of the frustum culling tester: input unpacking, plane chain, result register.
//
// Items arrive on the s_ channel; s_tuser carries the command (load plane, test point,
// test sphere, test box) and s_tdata the remaining fields. A load writes no result.
// Each test returns one transfer on the m_ channel whose m_tdata bit 0 is the visible flag.
// The item passes a chain of NUM_PLANES plane cells, each cell a three-stage
// multiply-accumulate over the x, y and z terms of its plane. A load travels the same
// chain and is captured by its cell on the way, so results always follow input order.
// One item is accepted every cycle unless the chain is full behind a stalled receiver;
// each cell stage has a single multiplier, which holds every pipeline register to one
// product and its accumulation.
// Reset clears all planes to zero; a zero plane passes every test.
// When the receiver stalls, the result waits in the output register and the chain keeps
// filling its empty stages; s_tready falls only once every stage holds an item.
`include "assert_macros.svh"

module frustum_cull_tester_core
  import fct_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // plane_index, plane_a, plane_b, plane_c, plane_offset, center_x, center_y,
  // center_z, extent_x, extent_y, extent_z
  input  logic [271:0] s_tdata,
  // command
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // visible
  output logic [7:0]   m_tdata
);

  item_t ch_item  [NUM_PLANES+1];
  logic  ch_valid [NUM_PLANES+1];
  logic  ch_ready [NUM_PLANES+1];
  logic  out_ready;
  logic  vis_q;

  always_comb begin
    ch_item[0].cmd          = cmd_t'(s_tuser);
    ch_item[0].plane_index  = s_tdata[2:0];
    ch_item[0].plane_a      = s_tdata[18:3];
    ch_item[0].plane_b      = s_tdata[34:19];
    ch_item[0].plane_c      = s_tdata[50:35];
    ch_item[0].plane_offset = s_tdata[82:51];
    ch_item[0].center_x     = s_tdata[114:83];
    ch_item[0].center_y     = s_tdata[146:115];
    ch_item[0].center_z     = s_tdata[178:147];
    ch_item[0].extent_x     = s_tdata[209:179];
    ch_item[0].extent_y     = s_tdata[240:210];
    ch_item[0].extent_z     = s_tdata[271:241];
    ch_item[0].vis          = 1'b1;
  end

  assign ch_valid[0] = s_tvalid;
  assign s_tready    = ch_ready[0];

  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_cell
    fct_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_idx  (CIDX_W'(i)),
      .in_valid  (ch_valid[i]),
      .in_ready  (ch_ready[i]),
      .in_item   (ch_item[i]),
      .out_valid (ch_valid[i+1]),
      .out_ready (ch_ready[i+1]),
      .out_item  (ch_item[i+1])
    );
  end

  assign out_ready            = !m_tvalid || m_tready;
  assign ch_ready[NUM_PLANES] = out_ready;

  // Loads leave the end of the chain here without a result transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= ch_valid[NUM_PLANES] && (ch_item[NUM_PLANES].cmd != CMD_LOAD);
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      vis_q <= ch_item[NUM_PLANES].vis;
    end
  end

  assign m_tdata = {7'b0, vis_q};

  `FCT_ASSERT_NEXT(a_load_no_result,
    ch_valid[NUM_PLANES] && ch_item[NUM_PLANES].cmd == CMD_LOAD && out_ready,
    !m_tvalid, "load item produced a result transfer")
  `FCT_ASSERT_NEXT(a_test_result,
    ch_valid[NUM_PLANES] && ch_item[NUM_PLANES].cmd != CMD_LOAD && out_ready,
    m_tvalid && m_tdata[0] == $past(ch_item[NUM_PLANES].vis),
    "test item did not reach the output register")
  `FCT_ASSERT_IMP(a_stall_source,
    !s_tready, m_tvalid && !m_tready,
    "input stalled without an output stall")

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the frustum culling tester core.
module tb;
  import fct_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    cmd_t               cmd;
    logic [2:0]         plane_index;
    logic signed [15:0] plane_a;
    logic signed [15:0] plane_b;
    logic signed [15:0] plane_c;
    logic signed [31:0] plane_offset;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        extent_x;
    logic [30:0]        extent_y;
    logic [30:0]        extent_z;
  } cull_req_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [271:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [7:0]   m_tdata;

  frustum_cull_tester_core dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  cull_req_t pending_reqs[$];
  bit        expected_vis[$];

  // Our own copy of the plane store.
  logic signed [15:0] pl_a [NUM_PLANES];
  logic signed [15:0] pl_b [NUM_PLANES];
  logic signed [15:0] pl_c [NUM_PLANES];
  logic signed [31:0] pl_d [NUM_PLANES];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  mismatches = 0;
  bit  in_fire = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_cnt = 0;
  int  queued_items = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [271:0] pack_req(cull_req_t r);
    return {r.extent_z, r.extent_y, r.extent_x, r.center_z, r.center_y, r.center_x,
            r.plane_offset, r.plane_c, r.plane_b, r.plane_a, r.plane_index};
  endfunction

  // Every plane must hold for the object to stay visible; sums are exact in Q.31.
  function automatic bit cull_visible(cull_req_t r);
    longint ex, ey, ez, s, a, b, c;
    bit vis;
    vis = 1'b1;
    ex = longint'({1'b0, r.extent_x});
    ey = longint'({1'b0, r.extent_y});
    ez = longint'({1'b0, r.extent_z});
    for (int i = 0; i < NUM_PLANES; i++) begin
      a = longint'(pl_a[i]);
      b = longint'(pl_b[i]);
      c = longint'(pl_c[i]);
      s = a * longint'(r.center_x) + b * longint'(r.center_y) + c * longint'(r.center_z)
          + longint'(pl_d[i]) * 32768;
      case (r.cmd)
        CMD_POINT:  if (s < 0) vis = 1'b0;
        CMD_SPHERE: if (s < -(ex * 32768)) vis = 1'b0;
        default: begin
          if (s + (a < 0 ? -a : a) * ex + (b < 0 ? -b : b) * ey + (c < 0 ? -c : c) * ez < 0)
            vis = 1'b0;
        end
      endcase
    end
    return vis;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(4))
      0: return 32'($urandom);
      1: return 32'($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
      2: return 32'($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
      3: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return 32'($urandom_range(32'h0000_4000)) - 32'sh0000_2000;
    endcase
  endfunction

  function automatic logic [30:0] rand_extent();
    case ($urandom_range(4))
      0: return 31'($urandom);
      1: return 31'($urandom_range(32'h0010_0000));
      2: return 31'($urandom_range(32'h0100_0000));
      3: return $urandom_range(1) ? 31'h7fff_ffff : 31'h0;
      default: return 31'($urandom_range(32'h0000_2000));
    endcase
  endfunction

  function automatic logic signed [15:0] rand_normal();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(8192)) - 16'sd4096;
      2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return 16'sd0;
    endcase
  endfunction

  function automatic cull_req_t rand_req(cmd_t cmd);
    cull_req_t r;
    r.cmd = cmd;
    r.plane_index = 3'($urandom);
    r.plane_a = 16'($urandom);
    r.plane_b = 16'($urandom);
    r.plane_c = 16'($urandom);
    r.plane_offset = 32'($urandom);
    r.center_x = rand_coord();
    r.center_y = rand_coord();
    r.center_z = rand_coord();
    r.extent_x = rand_extent();
    r.extent_y = rand_extent();
    r.extent_z = rand_extent();
    return r;
  endfunction

  task automatic push_load(input logic [2:0] idx, input logic signed [15:0] a,
                           input logic signed [15:0] b, input logic signed [15:0] c,
                           input logic signed [31:0] d);
    cull_req_t r;
    r = rand_req(CMD_LOAD);
    r.plane_index = idx;
    r.plane_a = a;
    r.plane_b = b;
    r.plane_c = c;
    r.plane_offset = d;
    pending_reqs.push_back(r);
    queued_items++;
  endtask

  task automatic push_test(input cmd_t cmd, input logic signed [31:0] x,
                           input logic signed [31:0] y, input logic signed [31:0] z,
                           input logic [30:0] ex, input logic [30:0] ey,
                           input logic [30:0] ez);
    cull_req_t r;
    r = rand_req(cmd);
    r.center_x = x;
    r.center_y = y;
    r.center_z = z;
    r.extent_x = ex;
    r.extent_y = ey;
    r.extent_z = ez;
    pending_reqs.push_back(r);
    queued_items++;
  endtask

  // A scene loads every plane, often clearing a few, then runs a burst of tests.
  task automatic push_scene();
    int n_tests;
    for (int i = 0; i < NUM_PLANES; i++) begin
      if ($urandom_range(2) == 0) begin
        push_load(3'(i), 16'sd0, 16'sd0, 16'sd0, 32'sd0);
      end else begin
        push_load(3'(i), rand_normal(), rand_normal(), rand_normal(),
                  $urandom_range(3) == 0 ? 32'($urandom) : rand_coord());
      end
    end
    // Out-of-range plane index: the load must be dropped.
    if ($urandom_range(3) == 0) begin
      push_load(3'($urandom_range(7, NUM_PLANES)), rand_normal(), rand_normal(),
                rand_normal(), 32'($urandom));
    end
    n_tests = $urandom_range(30, 8);
    for (int t = 0; t < n_tests; t++) begin
      if ($urandom_range(19) == 0) begin
        push_load(3'($urandom), rand_normal(), rand_normal(), rand_normal(), rand_coord());
      end else begin
        push_test(cmd_t'($urandom_range(3, 1)), rand_coord(), rand_coord(), rand_coord(),
                  rand_extent(), rand_extent(), rand_extent());
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || s_tvalid || expected_vis.size() > 0)
      @(posedge clk);
  endtask

  // Sender: holds the item until the transfer completes, then maybe idles.
  always @(negedge clk) begin : drive_in
    cull_req_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_reqs.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= pack_req(nxt);
        s_tuser <= nxt.cmd;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off.
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req && !hold_done) begin
      m_tready <= 1'b0;
      hold_cnt <= 199;
      hold_done <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : observe
    cull_req_t acc;
    bit want;
    in_fire <= s_tvalid && s_tready && !rst;
    if (rst) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        pl_a[i] = '0;
        pl_b[i] = '0;
        pl_c[i] = '0;
        pl_d[i] = '0;
      end
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_vis.size() == 0) begin
          if (mismatches < 10)
            $display("ERROR: unexpected result transfer, visible=%0b", m_tdata[0]);
          mismatches++;
        end else begin
          want = expected_vis.pop_front();
          if (m_tdata !== {7'b0, want}) begin
            if (mismatches < 10)
              $display("ERROR: visible mismatch, expected %0b got m_tdata=%b", want, m_tdata);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        acc.cmd = cmd_t'(s_tuser);
        {acc.extent_z, acc.extent_y, acc.extent_x, acc.center_z, acc.center_y, acc.center_x,
         acc.plane_offset, acc.plane_c, acc.plane_b, acc.plane_a, acc.plane_index} = s_tdata;
        if (acc.cmd == CMD_LOAD) begin
          if (acc.plane_index < NUM_PLANES) begin
            pl_a[acc.plane_index] = acc.plane_a;
            pl_b[acc.plane_index] = acc.plane_b;
            pl_c[acc.plane_index] = acc.plane_c;
            pl_d[acc.plane_index] = acc.plane_offset;
          end
        end else begin
          expected_vis.push_back(cull_visible(acc));
        end
      end
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed part. Cleared planes pass every test, even at the extremes.
    push_test(CMD_POINT, 32'sd0, 32'sd0, 32'sd0, 31'h0, 31'h0, 31'h0);
    push_test(CMD_BOX, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
              31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff);
    push_test(CMD_SPHERE, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
              31'h7fff_ffff, 31'h0, 31'h0);
    push_load(3'd6, 16'sh7fff, 16'sh7fff, 16'sh7fff, 32'sh8000_0000);
    push_load(3'd7, 16'sh8000, 16'sh8000, 16'sh8000, 32'sh8000_0000);
    push_test(CMD_POINT, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 31'h0, 31'h0, 31'h0);
    // Half space x >= 0 on plane 0.
    push_load(3'd0, 16'sh7fff, 16'sd0, 16'sd0, 32'sd0);
    push_test(CMD_POINT, -32'sd1, 32'sd0, 32'sd0, 31'h0, 31'h0, 31'h0);
    push_test(CMD_POINT, 32'sd0, 32'sd0, 32'sd0, 31'h0, 31'h0, 31'h0);
    push_test(CMD_SPHERE, -32'sd65536, 32'sd0, 32'sd0, 31'd65536, 31'h0, 31'h0);
    push_test(CMD_SPHERE, -32'sd131072, 32'sd0, 32'sd0, 31'd65536, 31'h0, 31'h0);
    push_test(CMD_BOX, -32'sd65536, 32'sd0, 32'sd0, 31'd65536, 31'd0, 31'd0);
    push_test(CMD_BOX, -32'sd65537, 32'sd0, 32'sd0, 31'd65535, 31'd0, 31'd0);
    push_load(3'd5, 16'sh8000, 16'sh8000, 16'sh8000, 32'sh7fff_ffff);
    push_load(3'd3, 16'sh7fff, 16'sh7fff, 16'sh7fff, 32'sh8000_0000);
    push_test(CMD_BOX, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
              31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff);
    push_test(CMD_SPHERE, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
              31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff);
    push_test(CMD_POINT, 32'sh7fff_ffff, 32'sh0, 32'sh7fff_ffff, 31'h0, 31'h0, 31'h0);
    push_test(CMD_BOX, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff);
    for (int i = 0; i < NUM_PLANES; i++)
      push_load(3'(i), 16'sd0, 16'sd0, 16'sd0, 32'sd0);
    push_test(CMD_SPHERE, 32'sh8000_0000, 32'sd0, 32'sd0, 31'h0, 31'h0, 31'h0);

    // Random part in three idling phases, draining fully between them.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 77 : 0;
      recv_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 27 : 0;
      while (queued_items < 400 * (ph + 1) + 25)
        push_scene();
      if (ph == 2) begin
        while (pending_reqs.size() > 250)
          @(posedge clk);
        hold_req = 1'b1;
      end
      wait_drained();
    end

    repeat (3 * NUM_PLANES + 20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/fct_pkg.sv
hdl/fct_cell.sv
hdl/frustum_cull_tester_core.sv
sim/tb.sv
